// ----- hdl/fsbm_pkg.sv -----
`timescale 1ns / 1ps
// fsbm_pkg: shared types and constants of the four-slot 8 KB bank mapper
// no dependencies; used by every module of the mapper

package fsbm_pkg;

    // bank slot storage
    localparam int SLOT_COUNT = 4;
    localparam int SLOT_IDX_W = $clog2(SLOT_COUNT);
    localparam int SLOT_W     = 8;

    // default width of the internal rom address space
    localparam int ROM_ADDRESS_BITS_DEF = 21;

    // field widths of the bus side and the target side
    localparam int BUS_ADDR_W  = 16;
    localparam int DATA_W      = 8;
    localparam int KIND_W      = 3;
    localparam int TGT_ADDR_W  = 21;
    localparam int PAGE_BITS   = 13;
    localparam int PAGES_W     = 9;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 9;

    // memory map boundaries
    localparam logic [BUS_ADDR_W-1:0] FIXED_PAGE_END = 16'h2000;
    localparam logic [BUS_ADDR_W-1:0] ROM_DIRECT_END = 16'h4000;
    localparam logic [BUS_ADDR_W-1:0] RAM_BASE       = 16'hC000;
    localparam logic [BUS_ADDR_W-1:0] BANK_REG_END   = 16'h0004;
    localparam logic [PAGE_BITS:0]    PAGE_BYTES     = 14'h2000;

    // register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FIXED_LOW_PAGE = 1'b0,
        CFG_ROM_SIZE_PAGES = 1'b1
    } t_cfg_index;

    // target operation codes
    typedef enum logic [KIND_W-1:0] {
        KIND_ROM_READ    = 3'd0,
        KIND_RAM_READ    = 3'd1,
        KIND_RAM_WRITE   = 3'd2,
        KIND_BANK_SET    = 3'd3,
        KIND_ROM_IGNORED = 3'd4
    } t_kind;

    // configuration register contents
    typedef struct packed {
        logic               fixed_low_page;
        logic [PAGES_W-1:0] rom_size_pages;
    } t_cfg;

    // one translated access
    typedef struct packed {
        t_kind                  kind;
        logic [TGT_ADDR_W-1:0]  addr;
        logic [DATA_W-1:0]      data;
        logic                   two_beats;
        logic                   bank_we;
        logic [SLOT_IDX_W-1:0]  bank_idx;
    } t_xlate;

endpackage

// ----- hdl/fsbm_regs.sv -----
`timescale 1ns / 1ps
// fsbm_regs: configuration registers and the four bank slot registers
// depends on fsbm_pkg

module fsbm_regs (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_cfg_we,
    input  logic [fsbm_pkg::CFG_INDEX_W-1:0]                i_cfg_index,
    input  logic [fsbm_pkg::CFG_DATA_W-1:0]                 i_cfg_data,
    input  logic                                            i_bank_we,
    input  logic [fsbm_pkg::SLOT_IDX_W-1:0]                 i_bank_idx,
    input  logic [fsbm_pkg::SLOT_W-1:0]                     i_bank_data,
    output fsbm_pkg::t_cfg                                  o_cfg,
    output logic [fsbm_pkg::SLOT_COUNT-1:0][fsbm_pkg::SLOT_W-1:0] o_slots
);

    fsbm_pkg::t_cfg r_cfg;
    logic [fsbm_pkg::SLOT_COUNT-1:0][fsbm_pkg::SLOT_W-1:0] r_slots;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fixed_low_page <= 1'b0;
            r_cfg.rom_size_pages <= fsbm_pkg::PAGES_W'(1);
        end else if (i_cfg_we) begin
            case (fsbm_pkg::t_cfg_index'(i_cfg_index))
                fsbm_pkg::CFG_FIXED_LOW_PAGE: begin
                    r_cfg.fixed_low_page <= i_cfg_data[0];
                end
                fsbm_pkg::CFG_ROM_SIZE_PAGES: begin
                    r_cfg.rom_size_pages <= i_cfg_data[fsbm_pkg::PAGES_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // bank slot writes from the bus
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= '0;
        end else if (i_bank_we) begin
            r_slots[i_bank_idx] <= i_bank_data;
        end
    end

    assign o_cfg   = r_cfg;
    assign o_slots = r_slots;

endmodule

// ----- hdl/fsbm_xlate.sv -----
`timescale 1ns / 1ps
// fsbm_xlate: decodes one bus access into a target operation
// depends on fsbm_pkg; purely combinational

module fsbm_xlate #(
    parameter int ROM_ADDRESS_BITS = fsbm_pkg::ROM_ADDRESS_BITS_DEF
) (
    input  logic                                  i_func,
    input  logic [fsbm_pkg::BUS_ADDR_W-1:0]       i_addr,
    input  logic [fsbm_pkg::DATA_W-1:0]           i_data,
    input  fsbm_pkg::t_cfg                        i_cfg,
    input  logic [fsbm_pkg::SLOT_COUNT-1:0][fsbm_pkg::SLOT_W-1:0] i_slots,
    output fsbm_pkg::t_xlate                      o_xlate
);

    logic [ROM_ADDRESS_BITS-1:0] fix_base;
    logic [ROM_ADDRESS_BITS-1:0] fix_addr;
    logic [ROM_ADDRESS_BITS-1:0] bank_addr;
    logic [ROM_ADDRESS_BITS-1:0] low_addr;
    logic [fsbm_pkg::SLOT_IDX_W-1:0] win_slot;

    // fixed low page: last rom page, wrapping in the rom address space
    assign fix_base = ROM_ADDRESS_BITS'({i_cfg.rom_size_pages, {fsbm_pkg::PAGE_BITS{1'b0}}})
                    - ROM_ADDRESS_BITS'(fsbm_pkg::PAGE_BYTES);
    assign fix_addr = fix_base + ROM_ADDRESS_BITS'(i_addr);

    // windows 0x4000..0xBFFF use slots 2, 3, 0, 1
    assign win_slot  = i_addr[fsbm_pkg::PAGE_BITS +: fsbm_pkg::SLOT_IDX_W];
    assign bank_addr = ROM_ADDRESS_BITS'({i_slots[win_slot],
                                          i_addr[fsbm_pkg::PAGE_BITS-1:0]});

    // low 16 KB, optionally with the fixed page below 0x2000
    assign low_addr = (i_cfg.fixed_low_page && (i_addr < fsbm_pkg::FIXED_PAGE_END))
                    ? fix_addr : ROM_ADDRESS_BITS'(i_addr);

    // access decode
    always_comb begin
        o_xlate           = '0;
        o_xlate.bank_idx  = i_addr[fsbm_pkg::SLOT_IDX_W-1:0];
        if (!i_func) begin
            if (i_addr < fsbm_pkg::ROM_DIRECT_END) begin
                o_xlate.kind = fsbm_pkg::KIND_ROM_READ;
                o_xlate.addr = fsbm_pkg::TGT_ADDR_W'(low_addr);
            end else if (i_addr < fsbm_pkg::RAM_BASE) begin
                o_xlate.kind = fsbm_pkg::KIND_ROM_READ;
                o_xlate.addr = fsbm_pkg::TGT_ADDR_W'(bank_addr);
            end else begin
                o_xlate.kind = fsbm_pkg::KIND_RAM_READ;
                o_xlate.addr = fsbm_pkg::TGT_ADDR_W'(i_addr);
            end
        end else begin
            o_xlate.addr = fsbm_pkg::TGT_ADDR_W'(i_addr);
            if (i_addr < fsbm_pkg::BANK_REG_END) begin
                o_xlate.kind    = fsbm_pkg::KIND_BANK_SET;
                o_xlate.data    = i_data;
                o_xlate.bank_we = 1'b1;
            end else if (i_addr < fsbm_pkg::RAM_BASE) begin
                o_xlate.kind = fsbm_pkg::KIND_ROM_IGNORED;
            end else begin
                o_xlate.kind      = fsbm_pkg::KIND_RAM_WRITE;
                o_xlate.data      = i_data;
                o_xlate.two_beats = 1'b1;
            end
        end
    end

endmodule

// ----- hdl/fsbm_out_stage.sv -----
`timescale 1ns / 1ps
// fsbm_out_stage: result register; sends the ram mirror as a second beat
// depends on fsbm_pkg

module fsbm_out_stage (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  fsbm_pkg::t_xlate                    i_xlate,
    output logic                                o_free,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [fsbm_pkg::KIND_W-1:0]         o_target_kind,
    output logic [fsbm_pkg::TGT_ADDR_W-1:0]     o_target_address,
    output logic [fsbm_pkg::DATA_W-1:0]         o_target_data,
    output logic                                o_last_of_access
);

    logic                              r_valid;
    logic                              r_two;
    fsbm_pkg::t_kind                   r_kind;
    logic [fsbm_pkg::TGT_ADDR_W-1:0]   r_addr;
    logic [fsbm_pkg::DATA_W-1:0]       r_data;
    logic                              beat_done;

    assign beat_done = r_valid && !i_out_stall;
    assign o_free    = !r_valid || (beat_done && !r_two);

    // control: valid and pending mirror beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_two   <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_two   <= i_xlate.two_beats;
        end else if (beat_done) begin
            r_valid <= r_two;
            r_two   <= 1'b0;
        end
    end

    // payload: mirror address is the other 8 KB half
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_kind <= i_xlate.kind;
            r_addr <= i_xlate.addr;
            r_data <= i_xlate.data;
        end else if (beat_done && r_two) begin
            r_addr[fsbm_pkg::PAGE_BITS] <= !r_addr[fsbm_pkg::PAGE_BITS];
        end
    end

    assign o_out_valid      = r_valid;
    assign o_target_kind    = r_kind;
    assign o_target_address = r_addr;
    assign o_target_data    = r_data;
    assign o_last_of_access = !r_two;

    // a pending mirror beat only exists for ram writes
    a_two_is_ram_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_two |-> (r_valid && r_kind == fsbm_pkg::KIND_RAM_WRITE))
        else $error("mirror beat pending on a non ram write");

    // first ram write beat taken: mirror beat follows with flipped page bit
    a_mirror_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (beat_done && r_two) |=> (r_valid && !r_two &&
            r_addr == ($past(r_addr) ^ fsbm_pkg::TGT_ADDR_W'(fsbm_pkg::PAGE_BYTES))))
        else $error("mirror beat missing or wrong address");

    // no load while a beat is still owed
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!r_valid || (beat_done && !r_two)))
        else $error("result register overwritten");

endmodule

// ----- hdl/four_slot_8k_bank_mapper_unit.sv -----
`timescale 1ns / 1ps
// four_slot_8k_bank_mapper_unit: top level of the 8 KB bank mapper
// depends on fsbm_pkg, fsbm_regs, fsbm_xlate, fsbm_out_stage
//
//   channel   handshake                  beat payload
//   -------   -------------------------  ---------------------------------------
//   in        i_in_valid / o_in_stall    i_func, i_bus_address, i_write_data
//   out       o_out_valid / i_out_stall  o_target_kind, o_target_address,
//                                        o_target_data, o_last_of_access
//   cfg       i_cfg_we                   i_cfg_index, i_cfg_data
//
// an access passes through the input register and then the result register
// reads, bank sets and ignored writes sustain one access per cycle while i_out_stall
// is low; a ram write occupies the result register for its first beat and its mirror beat
// bank slots update when the access moves into the result register
// synchronous active-low reset clears valids and bank slots, and sets the configuration
// to one rom page with no fixed low page; with both stages full o_in_stall follows
// i_out_stall in the same cycle, and it stays high through the first beat of a ram write

module four_slot_8k_bank_mapper_unit #(
    parameter int ROM_ADDRESS_BITS = fsbm_pkg::ROM_ADDRESS_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [fsbm_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [fsbm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // bus access input
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_func,
    input  logic [fsbm_pkg::BUS_ADDR_W-1:0]     i_bus_address,
    input  logic [fsbm_pkg::DATA_W-1:0]         i_write_data,
    // target output
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [fsbm_pkg::KIND_W-1:0]         o_target_kind,
    output logic [fsbm_pkg::TGT_ADDR_W-1:0]     o_target_address,
    output logic [fsbm_pkg::DATA_W-1:0]         o_target_data,
    output logic                                o_last_of_access
);

    logic                              r_in_valid;
    logic                              r_func;
    logic [fsbm_pkg::BUS_ADDR_W-1:0]   r_addr;
    logic [fsbm_pkg::DATA_W-1:0]       r_data;
    logic                              out_free;
    logic                              move;
    logic                              in_ready;
    fsbm_pkg::t_cfg                    cfg;
    fsbm_pkg::t_xlate                  xlate;
    logic [fsbm_pkg::SLOT_COUNT-1:0][fsbm_pkg::SLOT_W-1:0] slots;

    // stage handoff
    assign move       = r_in_valid && out_free;
    assign in_ready   = !r_in_valid || move;
    assign o_in_stall = !in_ready;

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_func <= i_func;
            r_addr <= i_bus_address;
            r_data <= i_write_data;
        end
    end

    fsbm_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_bank_we   (move && xlate.bank_we),
        .i_bank_idx  (xlate.bank_idx),
        .i_bank_data (xlate.data),
        .o_cfg       (cfg),
        .o_slots     (slots)
    );

    fsbm_xlate #(
        .ROM_ADDRESS_BITS (ROM_ADDRESS_BITS)
    ) u_xlate (
        .i_func  (r_func),
        .i_addr  (r_addr),
        .i_data  (r_data),
        .i_cfg   (cfg),
        .i_slots (slots),
        .o_xlate (xlate)
    );

    fsbm_out_stage u_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (move),
        .i_xlate          (xlate),
        .o_free           (out_free),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_target_kind    (o_target_kind),
        .o_target_address (o_target_address),
        .o_target_data    (o_target_data),
        .o_last_of_access (o_last_of_access)
    );

    // a held access moves on as soon as the result register frees up
    a_move_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_free) |=> o_out_valid)
        else $error("access not moved into result register");

    // a bank set reaches its slot in the cycle after the handoff
    a_bank_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && xlate.bank_we) |=>
            (slots[$past(xlate.bank_idx)] == $past(xlate.data)))
        else $error("bank slot not updated");

    // an empty input register never stalls the input
    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_in_stall)
        else $error("input stalled while empty");

endmodule
